@@ rtl/hsv_rgb_pkg.sv @@
// Shared constants and helpers for the HSV to RGB565 converter.
package hsv_rgb_pkg;

  localparam int unsigned ChanWidth   = 8;
  localparam int unsigned RgbWidth    = 16;
  localparam int unsigned RegionWidth = 3;
  localparam int unsigned RemWidth    = 6;

  localparam logic [ChanWidth-1:0] RegionSteps = 8'd43;
  localparam logic [ChanWidth-1:0] FullLevel   = 8'd255;

  localparam logic [RegionWidth-1:0] REGION_RED_YEL = 3'd0;
  localparam logic [RegionWidth-1:0] REGION_YEL_GRN = 3'd1;
  localparam logic [RegionWidth-1:0] REGION_GRN_CYN = 3'd2;
  localparam logic [RegionWidth-1:0] REGION_CYN_BLU = 3'd3;
  localparam logic [RegionWidth-1:0] REGION_BLU_MAG = 3'd4;
  localparam logic [RegionWidth-1:0] REGION_MAG_RED = 3'd5;

  // Split a hue into region and in-region remainder (hue / 43, hue % 43).
  function automatic logic [RegionWidth+RemWidth-1:0] hue_split(
    input logic [ChanWidth-1:0] hue
  );
    logic [RegionWidth-1:0] region;
    logic [ChanWidth-1:0]   base;
    logic [ChanWidth-1:0]   rem;
    if (hue >= 8'(5 * RegionSteps)) begin
      region = REGION_MAG_RED;
      base   = 8'(5 * RegionSteps);
    end else if (hue >= 8'(4 * RegionSteps)) begin
      region = REGION_BLU_MAG;
      base   = 8'(4 * RegionSteps);
    end else if (hue >= 8'(3 * RegionSteps)) begin
      region = REGION_CYN_BLU;
      base   = 8'(3 * RegionSteps);
    end else if (hue >= 8'(2 * RegionSteps)) begin
      region = REGION_GRN_CYN;
      base   = 8'(2 * RegionSteps);
    end else if (hue >= RegionSteps) begin
      region = REGION_YEL_GRN;
      base   = RegionSteps;
    end else begin
      region = REGION_RED_YEL;
      base   = 8'd0;
    end
    rem = hue - base;
    return {region, rem[RemWidth-1:0]};
  endfunction

  // Level product: (a * b) >> 8.
  function automatic logic [ChanWidth-1:0] lvl_mul(
    input logic [ChanWidth-1:0] a,
    input logic [ChanWidth-1:0] b
  );
    logic [2*ChanWidth-1:0] prod;
    prod = a * b;
    return prod[2*ChanWidth-1:ChanWidth];
  endfunction

endpackage

@@ rtl/hsv_to_rgb565_converter.sv @@
// HSV to RGB565 converter: four-stage pipeline, one pixel per clock unless stalled.
//
// Usage:
//   Input channel: in_valid_i with hue_i, saturation_i, brightness_i; the
//   block drives in_stall_o. A transfer happens on a rising edge with valid
//   high and stall low.
//   Output channel: out_valid_o with rgb565_o; the receiver drives
//   out_stall_i. Red sits in bits 15..11, green 10..5, blue 4..0.
//   Throughput is one pixel per cycle while the receiver does not stall.
//   A pixel passes through the four register stages in order: region split,
//   first products, second products, then channel routing and packing.
//   Reset empties the pipeline and drops any pixels in flight; out_valid_o
//   is low afterwards. Stalls neither lose nor repeat a pixel.
//   When the receiver stalls, the output register holds its pixel and the
//   stages behind it keep filling bubbles; once all four hold pixels,
//   in_stall_o rises in the same cycle and falls as soon as the receiver
//   lowers out_stall_i.
module hsv_to_rgb565_converter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [hsv_rgb_pkg::ChanWidth-1:0] hue_i,
  input  logic [hsv_rgb_pkg::ChanWidth-1:0] saturation_i,
  input  logic [hsv_rgb_pkg::ChanWidth-1:0] brightness_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [hsv_rgb_pkg::RgbWidth-1:0]  rgb565_o
);
  import hsv_rgb_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [RegionWidth-1:0] reg1_q, reg2_q, reg3_q;
  logic [ChanWidth-1:0]   f1_q, s1_q, val1_q;
  logic [ChanWidth-1:0]   val2_q, p2_q, sf2_q, sg2_q;
  logic [ChanWidth-1:0]   val3_q, p3_q, q3_q, t3_q;
  logic [RgbWidth-1:0]    rgb4_q;

  logic [RegionWidth+RemWidth-1:0] split;
  logic [RemWidth-1:0]             rem;
  logic [ChanWidth-1:0]            f_d;
  logic [ChanWidth-1:0]            r_c, g_c, b_c;
  logic [RgbWidth-1:0]             rgb_d;

  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v4_q;
  assign rgb565_o    = rgb4_q;

  assign split = hue_split(hue_i);
  assign rem   = split[RemWidth-1:0];
  assign f_d   = {rem, 2'b00} + {1'b0, rem, 1'b0};

  always_comb begin
    case (reg3_q)
      REGION_RED_YEL: begin r_c = val3_q; g_c = t3_q;   b_c = p3_q;   end
      REGION_YEL_GRN: begin r_c = q3_q;   g_c = val3_q; b_c = p3_q;   end
      REGION_GRN_CYN: begin r_c = p3_q;   g_c = val3_q; b_c = t3_q;   end
      REGION_CYN_BLU: begin r_c = p3_q;   g_c = q3_q;   b_c = val3_q; end
      REGION_BLU_MAG: begin r_c = t3_q;   g_c = p3_q;   b_c = val3_q; end
      default:        begin r_c = val3_q; g_c = p3_q;   b_c = q3_q;   end
    endcase
    rgb_d = {r_c[7:3], g_c[7:2], b_c[7:3]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      reg1_q <= split[RegionWidth+RemWidth-1:RemWidth];
      f1_q   <= f_d;
      s1_q   <= saturation_i;
      val1_q <= brightness_i;
    end
    if (rdy2 && v1_q) begin
      reg2_q <= reg1_q;
      val2_q <= val1_q;
      p2_q   <= lvl_mul(val1_q, FullLevel - s1_q);
      sf2_q  <= lvl_mul(s1_q, f1_q);
      sg2_q  <= lvl_mul(s1_q, FullLevel - f1_q);
    end
    if (rdy3 && v2_q) begin
      reg3_q <= reg2_q;
      val3_q <= val2_q;
      p3_q   <= p2_q;
      q3_q   <= lvl_mul(val2_q, FullLevel - sf2_q);
      t3_q   <= lvl_mul(val2_q, FullLevel - sg2_q);
    end
    if (rdy4 && v3_q) begin
      rgb4_q <= rgb_d;
    end
  end

endmodule
